// File: src/kvi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared types and constants of the keyframe vector interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = 7;
    localparam int FRAC_W   = 16;
    localparam int DCNT_W   = $clog2(FRAC_W + 1);

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] STAT_INTERP = 2'd0;
    localparam logic [1:0] STAT_SINGLE = 2'd1;
    localparam logic [1:0] STAT_CLAMP  = 2'd2;
    localparam logic [1:0] STAT_WRACK  = 2'd3;

    typedef logic [2:0][31:0] t_vec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCMP,
        ST_KEY,
        ST_T0,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] comp;
    } t_lerp_ctl;

endpackage
`default_nettype wire

// File: src/kvi_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_mem
// Keyframe table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kvi_mem
    import kvi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [KEY_AW-1:0] i_waddr,
    input  wire logic [31:0]       i_wtime,
    input  wire t_vec              i_wvec,
    input  wire logic [KEY_AW-1:0] i_raddr,
    output t_vec                   o_rvec,
    output logic [31:0]            o_rtime
);

    logic [31:0] r_times [MAX_KEYS];
    t_vec        r_vecs  [MAX_KEYS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_times[i_waddr] <= i_wtime;
            r_vecs[i_waddr]  <= i_wvec;
        end
        o_rtime <= r_times[i_raddr];
        o_rvec  <= r_vecs[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/kvi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_div
// Restoring divider, one quotient bit per cycle, for the Q0.16 blend factor.
// Requires num < den; gives floor(num * 2^16 / den).
// ----------------------------------------------------------------------------
module kvi_div
    import kvi_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_div_ctl     i_ctl,
    output t_div_sts          o_sts,
    output logic [FRAC_W-1:0] o_quot
);

    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [32:0]       w_sh;
    logic [32:0]       w_sub;
    logic              w_ge;

    assign w_sh  = {r_rem, 1'b0};
    assign w_sub = w_sh - {1'b0, r_den};
    assign w_ge  = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_ctl.num;
            r_den  <= i_ctl.den;
            o_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[31:0] : w_sh[31:0];
            o_quot <= {o_quot[FRAC_W-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule
`default_nettype wire

// File: src/kvi_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_lerp
// Shared blend unit: one 17x33 multiply per component, registered, then
// start + floor(product / 2^16) for the same component.
// ----------------------------------------------------------------------------
module kvi_lerp
    import kvi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_lerp_ctl         i_ctl,
    input  wire logic [FRAC_W-1:0] i_factor,
    input  wire t_vec              i_svec,
    input  wire t_vec              i_evec,
    output logic [31:0]            o_sum
);

    logic        [31:0] w_s;
    logic        [31:0] w_e;
    logic signed [32:0] w_diff;
    logic signed [49:0] w_prod;
    logic        [47:0] r_prod;

    always_comb begin
        case (i_ctl.comp)
            2'd0:    begin w_s = i_svec[0]; w_e = i_evec[0]; end
            2'd1:    begin w_s = i_svec[1]; w_e = i_evec[1]; end
            2'd2:    begin w_s = i_svec[2]; w_e = i_evec[2]; end
            default: begin w_s = i_svec[0]; w_e = i_evec[0]; end
        endcase
    end

    assign w_diff = $signed({w_e[31], w_e}) - $signed({w_s[31], w_s});
    assign w_prod = $signed({1'b0, i_factor}) * w_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod[47:0];
        end
    end

    // arithmetic shift floors; only the low 32 bits of the sum survive
    assign o_sum = w_s + r_prod[47:16];

endmodule
`default_nettype wire

// File: src/keyframe_vector_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator
// Keyframe table with linear interpolation of a 3-component Q16.16 vector.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): a write item (opcode 0) stores one
// key and is acknowledged; a query item (opcode 1) returns the vector blended
// between the two keys around query_time. One result per item on the output
// channel (o_out_valid / i_out_stall), held in an output register, so the
// next item is taken while a result still waits.
// Config channel (i_cfg_valid / o_cfg_ready) writes key_count; always ready,
// write it only while the block is idle.
// Per item: a write goes straight to the done state. A query walks the table
// one key a cycle through the single memory read port (up to key_count - 1
// keys), then a restoring divider forms the factor in 16 steps and signals
// done, and one shared multiplier blends the components in turn, a multiply
// and an add for each. A single-key query reads key 0 alone; clamped queries
// end after the search.
// Reset clears control state and sets key_count to 1; table contents are
// undefined until written. A stalled output holds; the block then finishes
// the next item and waits with it until the output register frees.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator
    import kvi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_opcode,
    input  wire logic [5:0]         i_key_slot,
    input  wire logic [31:0]        i_key_time,
    input  wire logic signed [31:0] i_key_x,
    input  wire logic signed [31:0] i_key_y,
    input  wire logic signed [31:0] i_key_z,
    input  wire logic [31:0]        i_query_time,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z,
    output logic [5:0]              o_segment,
    output logic [1:0]              o_status,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CNT_W-1:0]   i_cfg_data
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_key_count;
    logic [CNT_W-1:0]   w_eff_n;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [KEY_AW-1:0]  r_addr, n_addr;
    logic [31:0]        r_q, n_q;
    logic [31:0]        r_t1, n_t1;
    t_vec               r_svec, n_svec;
    logic [1:0]         r_comp, n_comp;
    t_vec               r_res_vec, n_res_vec;
    logic [5:0]         r_res_seg, n_res_seg;
    logic [1:0]         r_res_st, n_res_st;
    logic               r_out_valid;
    t_vec               r_out_vec;
    logic [5:0]         r_out_seg;
    logic [1:0]         r_out_st;

    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_we;
    logic               w_q_lt;
    logic               w_last;
    t_vec               w_rd_vec;
    logic [31:0]        w_rd_time;
    t_vec               w_wvec;
    t_div_ctl           w_div_ctl;
    t_div_sts           w_div_sts;
    logic [FRAC_W-1:0]  w_factor;
    t_lerp_ctl          w_lerp_ctl;
    logic [31:0]        w_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_we        = w_in_xfer && (i_opcode == OP_WRITE)
                         && ({1'b0, i_key_slot} < CNT_W'(MAX_KEYS));
    assign w_wvec      = {i_key_z, i_key_y, i_key_x};

    assign w_eff_n = (r_key_count == '0) ? CNT_W'(1) :
                     (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_key_count;

    assign w_q_lt = r_q < w_rd_time;
    assign w_last = ({1'b0, r_addr} + CNT_W'(1)) >= r_n;

    kvi_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_key_slot[KEY_AW-1:0]),
        .i_wtime (i_key_time),
        .i_wvec  (w_wvec),
        .i_raddr (n_addr),
        .o_rvec  (w_rd_vec),
        .o_rtime (w_rd_time)
    );

    kvi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_sts   (w_div_sts),
        .o_quot  (w_factor)
    );

    kvi_lerp u_lerp (
        .i_clk    (i_clk),
        .i_ctl    (w_lerp_ctl),
        .i_factor (w_factor),
        .i_svec   (r_svec),
        .i_evec   (w_rd_vec),
        .o_sum    (w_sum)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_opcode == OP_WRITE) begin
                        n_state = ST_DONE;
                    end else if (w_eff_n == CNT_W'(1)) begin
                        n_state = ST_KEY;
                    end else begin
                        n_state = ST_SCMP;
                    end
                end
            end
            ST_SCMP: begin
                if (w_q_lt) begin
                    n_state = ST_T0;
                end else if (w_last) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY:  n_state = ST_DONE;
            ST_T0:   n_state = w_q_lt ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (w_div_sts.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = (r_comp == 2'd2) ? ST_DONE : ST_MUL;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb begin
        n_n          = r_n;
        n_addr       = r_addr;
        n_q          = r_q;
        n_t1         = r_t1;
        n_svec       = r_svec;
        n_comp       = r_comp;
        n_res_vec    = r_res_vec;
        n_res_seg    = r_res_seg;
        n_res_st     = r_res_st;
        w_div_ctl    = '0;
        w_lerp_ctl   = '0;
        w_lerp_ctl.comp = r_comp;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_n  = w_eff_n;
                    n_q  = i_query_time;
                    if (i_opcode == OP_WRITE) begin
                        n_res_vec = '0;
                        n_res_seg = i_key_slot;
                        n_res_st  = STAT_WRACK;
                    end else if (w_eff_n == CNT_W'(1)) begin
                        n_addr    = '0;
                        n_res_seg = '0;
                        n_res_st  = STAT_SINGLE;
                    end else begin
                        n_addr = KEY_AW'(1);
                    end
                end
            end
            ST_SCMP: begin
                if (w_q_lt) begin
                    n_t1   = w_rd_time;
                    n_addr = r_addr - 1'b1;
                end else if (w_last) begin
                    // past the end: last key, segment key_count - 2
                    n_res_seg = 6'(r_addr - 1'b1);
                    n_res_st  = STAT_CLAMP;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_KEY: begin
                n_res_vec = w_rd_vec;
            end
            ST_T0: begin
                n_res_seg = 6'(r_addr);
                if (w_q_lt) begin
                    // before the segment start: start key unchanged
                    n_res_vec = w_rd_vec;
                    n_res_st  = STAT_CLAMP;
                end else begin
                    n_svec        = w_rd_vec;
                    n_addr        = r_addr + 1'b1;
                    n_res_st      = STAT_INTERP;
                    n_comp        = 2'd0;
                    w_div_ctl.start = 1'b1;
                    w_div_ctl.num   = r_q - w_rd_time;
                    w_div_ctl.den   = r_t1 - w_rd_time;
                end
            end
            ST_MUL: begin
                w_lerp_ctl.mul_en = 1'b1;
            end
            ST_ADD: begin
                case (r_comp)
                    2'd0:    n_res_vec[0] = w_sum;
                    2'd1:    n_res_vec[1] = w_sum;
                    2'd2:    n_res_vec[2] = w_sum;
                    default: n_res_vec[0] = w_sum;
                endcase
                n_comp = r_comp + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_count <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_key_count <= i_cfg_data;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_addr    <= n_addr;
        r_q       <= n_q;
        r_t1      <= n_t1;
        r_svec    <= n_svec;
        r_comp    <= n_comp;
        r_res_vec <= n_res_vec;
        r_res_seg <= n_res_seg;
        r_res_st  <= n_res_st;
        if (r_state == ST_DONE && w_out_free) begin
            r_out_vec <= r_res_vec;
            r_out_seg <= r_res_seg;
            r_out_st  <= r_res_st;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_vec[0];
    assign o_out_y     = r_out_vec[1];
    assign o_out_z     = r_out_vec[2];
    assign o_segment   = r_out_seg;
    assign o_status    = r_out_st;

`ifndef ASSERT_OFF
    a_wr_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_opcode == OP_WRITE) |=> (r_state == ST_DONE && r_res_st == STAT_WRACK))
        else $error("write transfer not acknowledged");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_div_sts.busy || w_div_sts.done))
        else $error("waiting on an idle divider");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCMP) |-> (r_addr != '0 && {1'b0, r_addr} < r_n))
        else $error("key search index out of range");
`endif

endmodule
`default_nettype wire
